// ----- src/tqws_pkg.sv -----
`default_nettype none

package tqws_pkg;

   localparam int ID_W    = 37;
   localparam int OP_W    = 2;
   localparam int BURST_W = 4;
   localparam int STAT_W  = 2;

   localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

   localparam logic [OP_W-1:0] OP_ENQ_NORMAL   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENQ_PRIORITY = 2'd1;
   localparam int              OP_SERVE_BIT    = 1;

   localparam logic [STAT_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_SERVED   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_DROPPED  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [ID_W-1:0] id_value;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   served_id;
      logic              served_queue;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic push_normal;
      logic push_priority;
      logic pop_normal;
      logic pop_priority;
      logic dropped;
      logic empty;
   } decision_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

// ----- src/two_queue_weighted_scheduler_top.sv -----
// Two-queue weighted scheduler: a normal and a priority FIFO of 37-bit identifiers.
// Request channel (req_valid/req_ready, req_payload): operation 0 enqueues into the
// normal queue, 1 into the priority queue, 2 or 3 serves the next identifier.
// Response channel (rsp_valid/rsp_ready, rsp_payload): one beat per request with
// served_id, served_queue and status (enqueued, served, both empty, full and dropped).
// csr_write_en/csr_write_data set the burst: after that many serves the priority
// head is taken next; write it only while no request is in flight.
// Enqueues and failed serves give their response beat in the cycle after acceptance;
// a successful serve first does the registered read of the queue memory (ST_READ),
// then loads the response register. A new request is taken once the response
// register is free or drains in the same cycle, and not while a serve is in ST_READ.
// A stalled receiver holds the response beat and blocks further requests.
// Synchronous reset empties both queues, clears the service counter and sets the
// burst to 3; queue memory contents are not cleared.
`default_nettype none

module two_queue_weighted_scheduler_top
   import tqws_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_payload,
   input  wire logic               csr_write_en,
   input  wire logic [BURST_W-1:0] csr_write_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               queue_ff, queue_in;
   logic               accept, load_direct, load_mem, go_read;
   decision_type       decision;
   logic [PTR_W-1:0]   n_head, n_tail, p_head, p_tail;
   logic [ID_W-1:0]    n_rd_data, p_rd_data;
   logic [STAT_W-1:0]  direct_status;

   tqws_sched #(.DEPTH(QUEUE_DEPTH)) u_sched (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .operation      (req_payload.operation),
      .decision       (decision),
      .normal_head    (n_head),
      .normal_tail    (n_tail),
      .priority_head  (p_head),
      .priority_tail  (p_tail)
   );

   tqws_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_normal_ram (
      .clock   (clock),
      .wr_en   (accept && decision.push_normal),
      .wr_addr (n_tail),
      .wr_data (req_payload.id_value),
      .rd_en   (accept && decision.pop_normal),
      .rd_addr (n_head),
      .rd_data (n_rd_data)
   );

   tqws_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_W)) u_priority_ram (
      .clock   (clock),
      .wr_en   (accept && decision.push_priority),
      .wr_addr (p_tail),
      .wr_data (req_payload.id_value),
      .rd_en   (accept && decision.pop_priority),
      .rd_addr (p_head),
      .rd_data (p_rd_data)
   );

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
         end
         ST_READ: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      accept      = req_valid && req_ready;
      go_read     = accept && (decision.pop_normal || decision.pop_priority);
      load_direct = accept && !go_read;
      load_mem    = (state_ff == ST_READ);
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = go_read ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (decision.empty) begin
         direct_status = STATUS_EMPTY;
      end else if (decision.dropped) begin
         direct_status = STATUS_DROPPED;
      end else begin
         direct_status = STATUS_ENQUEUED;
      end

      queue_in = go_read ? decision.pop_priority : queue_ff;

      rsp_in = rsp_ff;
      if (load_direct) begin
         rsp_in.served_id    = '0;
         rsp_in.served_queue = 1'b0;
         rsp_in.status       = direct_status;
      end else if (load_mem) begin
         rsp_in.served_id    = queue_ff ? p_rd_data : n_rd_data;
         rsp_in.served_queue = queue_ff;
         rsp_in.status       = STATUS_SERVED;
      end

      if (load_direct || load_mem) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff   <= rsp_in;
      queue_ff <= queue_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("response register occupied during queue read");

   a_read_follows_serve: assert property (@(posedge clock) disable iff (reset)
      go_read |=> state_ff == ST_READ && rsp_valid_ff == 1'b0)
      else $error("serve did not enter read state");

   a_served_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && rsp_ff.status == STATUS_SERVED)
      else $error("served beat not presented after read");
`endif

endmodule

`default_nettype wire

// ----- src/tqws_ram.sv -----
`default_nettype none

module tqws_ram
   import tqws_pkg::*;
#(
   parameter int  DEPTH  = 16,
   parameter int  WIDTH  = 37,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/tqws_sched.sv -----
`default_nettype none

module tqws_sched
   import tqws_pkg::*;
#(
   parameter int  DEPTH  = 16,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic [BURST_W-1:0] csr_write_data,
   input  wire logic               accept,
   input  wire logic [OP_W-1:0]    operation,
   output decision_type            decision,
   output logic      [PTR_W-1:0]   normal_head,
   output logic      [PTR_W-1:0]   normal_tail,
   output logic      [PTR_W-1:0]   priority_head,
   output logic      [PTR_W-1:0]   priority_tail
);

   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [BURST_W-1:0] counter_ff, counter_in;
   logic [PTR_W-1:0]   n_head_ff, n_head_in, n_tail_ff, n_tail_in;
   logic [PTR_W-1:0]   p_head_ff, p_head_in, p_tail_ff, p_tail_in;
   logic [CNT_W-1:0]   n_count_ff, n_count_in, p_count_ff, p_count_in;
   logic               is_serve, n_empty, p_empty, n_full, p_full, take_priority;
   logic [BURST_W-1:0] counter_base;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      is_serve      = operation[OP_SERVE_BIT];
      n_empty       = (n_count_ff == '0);
      p_empty       = (p_count_ff == '0);
      n_full        = (n_count_ff == CNT_W'(DEPTH));
      p_full        = (p_count_ff == CNT_W'(DEPTH));
      take_priority = !p_empty && ((counter_ff >= burst_ff) || n_empty);

      decision.push_normal   = !is_serve && (operation == OP_ENQ_NORMAL) && !n_full;
      decision.push_priority = !is_serve && (operation == OP_ENQ_PRIORITY) && !p_full;
      decision.dropped       = !is_serve && ((operation == OP_ENQ_NORMAL) ? n_full : p_full);
      decision.empty         = is_serve && n_empty && p_empty;
      decision.pop_priority  = is_serve && take_priority;
      decision.pop_normal    = is_serve && !take_priority && !n_empty;
   end

   always_comb begin
      burst_in   = csr_write_en ? csr_write_data : burst_ff;
      n_head_in  = n_head_ff;
      n_tail_in  = n_tail_ff;
      n_count_in = n_count_ff;
      p_head_in  = p_head_ff;
      p_tail_in  = p_tail_ff;
      p_count_in = p_count_ff;
      counter_in = counter_ff;
      counter_base = decision.pop_priority ? '0 : counter_ff;
      if (accept) begin
         if (decision.push_normal) begin
            n_tail_in  = wrap_inc(n_tail_ff);
            n_count_in = n_count_ff + 1'b1;
         end
         if (decision.push_priority) begin
            p_tail_in  = wrap_inc(p_tail_ff);
            p_count_in = p_count_ff + 1'b1;
         end
         if (decision.pop_normal) begin
            n_head_in  = wrap_inc(n_head_ff);
            n_count_in = n_count_ff - 1'b1;
         end
         if (decision.pop_priority) begin
            p_head_in  = wrap_inc(p_head_ff);
            p_count_in = p_count_ff - 1'b1;
         end
         if (decision.pop_normal || decision.pop_priority) begin
            counter_in = (counter_base >= burst_ff) ? burst_ff : counter_base + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff   <= BURST_RESET;
         counter_ff <= '0;
         n_head_ff  <= '0;
         n_tail_ff  <= '0;
         n_count_ff <= '0;
         p_head_ff  <= '0;
         p_tail_ff  <= '0;
         p_count_ff <= '0;
      end else begin
         burst_ff   <= burst_in;
         counter_ff <= counter_in;
         n_head_ff  <= n_head_in;
         n_tail_ff  <= n_tail_in;
         n_count_ff <= n_count_in;
         p_head_ff  <= p_head_in;
         p_tail_ff  <= p_tail_in;
         p_count_ff <= p_count_in;
      end
   end

   assign normal_head   = n_head_ff;
   assign normal_tail   = n_tail_ff;
   assign priority_head = p_head_ff;
   assign priority_tail = p_tail_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (n_count_ff <= CNT_W'(DEPTH)) && (p_count_ff <= CNT_W'(DEPTH)))
      else $error("queue occupancy above depth");

   a_counter_clamp: assert property (@(posedge clock) disable iff (reset)
      accept && (decision.pop_normal || decision.pop_priority) && !csr_write_en
      |=> counter_ff <= burst_ff)
      else $error("service counter above burst after a serve");

   a_pop_normal: assert property (@(posedge clock) disable iff (reset)
      accept && decision.pop_normal |=> n_count_ff == $past(n_count_ff) - 1'b1)
      else $error("normal occupancy not decremented on serve");

   a_prio_counter: assert property (@(posedge clock) disable iff (reset)
      accept && decision.pop_priority |=> counter_ff <= 4'd1)
      else $error("service counter not restarted on priority serve");
`endif

endmodule

`default_nettype wire
